@@ src/flat_triangle_zbuffer_raster_core_macros.svh @@
// Assertion macros used by the checker file of the raster core.
`ifndef FLAT_TRIANGLE_ZBUFFER_RASTER_CORE_MACROS_SVH
`define FLAT_TRIANGLE_ZBUFFER_RASTER_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define FZR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("raster core check failed");

// The consequent must hold in the same cycle as the antecedent.
`define FZR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("raster core check failed");

`endif

@@ src/fzr_pkg.sv @@
package fzr_pkg;

  localparam int X_W     = 48;
  localparam int SLOPE_W = 34;
  localparam int Y_W     = 19;
  localparam int DX_W    = 17;
  localparam int COL_W   = 7;

  localparam logic signed [15:0] CLEAR_DEPTH = -16'sd16000;
  localparam logic [6:0]  ACTIVE_WIDTH_RST = 7'd64;
  localparam logic [11:0] Y_ORIGIN_RST     = 12'd800;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic REG_ACTIVE_WIDTH = 1'b0;
  localparam logic REG_Y_ORIGIN     = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV0,
    S_DIV1,
    S_TEST_UP,
    S_DIV2,
    S_TEST_LO,
    S_WALK,
    S_RMW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                   start;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SLOPE_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ src/fzr_if.sv @@
interface fzr_prim_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] v0_x;
  logic signed [15:0] v0_y;
  logic signed [15:0] v0_z;
  logic signed [15:0] v1_x;
  logic signed [15:0] v1_y;
  logic signed [15:0] v1_z;
  logic signed [15:0] v2_x;
  logic signed [15:0] v2_y;
  logic signed [15:0] v2_z;
  logic [23:0]        face_rgb;

  modport source(output valid, op, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                 v2_x, v2_y, v2_z, face_rgb, input ready);
  modport sink(input valid, op, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
               v2_x, v2_y, v2_z, face_rgb, output ready);
endinterface

interface fzr_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row;
  logic [63:0] pixel_mask;
  logic [23:0] pixel_rgb;
  logic        last;

  modport source(output valid, row, pixel_mask, pixel_rgb, last, input ready);
  modport sink(input valid, row, pixel_mask, pixel_rgb, last, output ready);
endinterface

@@ src/fzr_ram.sv @@
module fzr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fzr_div.sv @@
// Restoring divider: one quotient bit per cycle, sign applied at the end.
module fzr_div import fzr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] num;
  logic [31:0] quo;
  logic [15:0] den;
  logic [15:0] rem;
  logic        neg;
  logic [16:0] trial;
  logic        fits;
  logic [16:0] dx_mag;
  logic [16:0] dy_mag;

  always_comb begin
    dx_mag = req.dx[DX_W-1] ? 17'(-req.dx) : 17'(req.dx);
    dy_mag = req.dy[DX_W-1] ? 17'(-req.dy) : 17'(req.dy);
    trial  = {rem, num[31]};
    fits   = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        num  <= {dx_mag[15:0], 16'd0};
        den  <= dy_mag[15:0];
        rem  <= 16'd0;
        quo  <= 32'd0;
        neg  <= req.dx[DX_W-1] ^ req.dy[DX_W-1];
      end else if (busy) begin
        rem <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
        quo <= {quo[30:0], fits};
        num <= {num[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = neg ? -$signed(SLOPE_W'(quo)) : $signed(SLOPE_W'(quo));

endmodule

@@ src/flat_triangle_zbuffer_raster_core.sv @@
// Clear beat: no result; the depth store is invalidated by clearing all row flags.
// Draw beat: a slope division per edge, then the walk state steps each scanline
// above the screen alone, and each visited scanline takes a depth row read, then
// compare and write back, which stalls while the held-back row cannot be passed on.
// One triangle at a time; the result register lets the next beat enter while the final
// result waits. Synchronous active-high reset clears control and row flags, not datapath.
module flat_triangle_zbuffer_raster_core import fzr_pkg::*; #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fzr_prim_if.sink    prim,
  fzr_res_if.source   res
);

  localparam int ROW_W = $clog2(SCREEN_H);
  localparam int MEM_W = SCREEN_W * 16;
  localparam logic signed [Y_W-1:0] Y_LIMIT = Y_W'(SCREEN_H * 16);
  localparam logic signed [Y_W-1:0] Y_STEP  = Y_W'(16);

  // Configuration registers.
  logic [6:0]  aw;
  logic [11:0] yorg;

  state_t state;
  state_t state_next;

  // Triangle state: sorted vertices (y already flipped), edge positions and slopes
  // in 16 fraction bits, the current scanline y in Q15.4.
  logic signed [15:0]      vx0, vx1, vx2;
  logic signed [Y_W-1:0]   yv1, yv2;
  logic signed [Y_W-1:0]   y;
  logic signed [15:0]      z;
  logic [23:0]             rgb;
  logic signed [X_W-1:0]   x0, x1;
  logic signed [SLOPE_W-1:0] s0, s1;
  logic                    ok0, ok1;
  logic                    half;
  logic                    div_run;

  // Scanline work and the held-back row result.
  logic [ROW_W-1:0]    rowaddr;
  logic [ROW_W-1:0]    rd_row;
  logic [SCREEN_W-1:0] colmask;
  logic [SCREEN_H-1:0] rvalid;
  logic                pend_valid;
  logic [ROW_W-1:0]    pend_row;
  logic [63:0]         pend_mask;

  // Result register.
  logic        out_valid;
  logic [5:0]  out_row;
  logic [63:0] out_mask;
  logic [23:0] out_rgb;
  logic        out_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [MEM_W-1:0] row_rdata;
  logic [MEM_W-1:0] row_wdata;
  logic             ram_we;

  logic accept;
  logic out_free;
  logic edges_ok;
  logic y_done;
  logic y_off;
  logic y_neg;
  logic rmw_go;
  logic dy_zero;

  // Sorting of the incoming vertices.
  logic signed [15:0]    vx_in [3];
  logic signed [15:0]    vy_in [3];
  logic signed [15:0]    vz_in [3];
  logic [1:0]            rank [3];
  logic signed [15:0]    sx [3];
  logic signed [15:0]    sy [3];
  logic signed [15:0]    sz [3];
  logic signed [Y_W-1:0] yf [3];

  // Column range of the scanline.
  logic signed [X_W-1:0] mn, mx;
  logic [COL_W-1:0]      col_start, col_end, col_limit;
  logic [SCREEN_W-1:0]   colmask_calc;
  logic signed [15:0]    cur_depth [SCREEN_W];
  logic [SCREEN_W-1:0]   hit;

  function automatic logic edge_ok(input logic signed [SLOPE_W-1:0] s,
                                   input logic signed [X_W-1:0] x);
    logic signed [X_W-1:0] sum;
    logic signed [X_W-1:0] bound;
    sum   = x + X_W'(s);
    bound = $signed(X_W'({aw, 16'd0}));
    return (sum > 0) && (sum < bound);
  endfunction

  fzr_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // The row is addressed while the walk state picks it, so that its depths are
  // on the read port in the following read-modify-write cycle.
  assign rd_row = (state == S_WALK) ? y[4 +: ROW_W] : rowaddr;

  // One entry per screen row, one 16-bit depth per column.
  fzr_ram #(.WIDTH(MEM_W), .DEPTH(SCREEN_H)) u_depth (
    .clk  (clk),
    .we   (ram_we),
    .waddr(rowaddr),
    .wdata(row_wdata),
    .raddr(rd_row),
    .rdata(row_rdata)
  );

  // APB configuration port: always ready, registers at byte offsets 0 and 4.
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_WIDTH: prdata = 32'(aw);
      REG_Y_ORIGIN:     prdata = 32'(yorg);
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aw   <= ACTIVE_WIDTH_RST;
      yorg <= Y_ORIGIN_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ACTIVE_WIDTH: aw   <= pwdata[6:0];
        REG_Y_ORIGIN:     yorg <= pwdata[11:0];
        default:          aw   <= aw;
      endcase
    end
  end

  assign prim.ready = (state == S_IDLE);
  assign accept     = prim.valid && prim.ready;
  assign out_free   = !out_valid || res.ready;

  // Stable sort by y, largest first: a later vertex passes an earlier one only
  // when strictly larger. The sorted y values are then flipped about y_origin.
  always_comb begin
    vx_in[0] = prim.v0_x; vy_in[0] = prim.v0_y; vz_in[0] = prim.v0_z;
    vx_in[1] = prim.v1_x; vy_in[1] = prim.v1_y; vz_in[1] = prim.v1_z;
    vx_in[2] = prim.v2_x; vy_in[2] = prim.v2_y; vz_in[2] = prim.v2_z;
    rank[0] = 2'(vy_in[1] > vy_in[0]) + 2'(vy_in[2] > vy_in[0]);
    rank[1] = 2'(vy_in[0] >= vy_in[1]) + 2'(vy_in[2] > vy_in[1]);
    rank[2] = 2'(vy_in[0] >= vy_in[2]) + 2'(vy_in[1] >= vy_in[2]);
    for (int p = 0; p < 3; p++) begin
      sx[p] = vx_in[0];
      sy[p] = vy_in[0];
      sz[p] = vz_in[0];
      for (int i = 0; i < 3; i++) begin
        if (rank[i] == 2'(p)) begin
          sx[p] = vx_in[i];
          sy[p] = vy_in[i];
          sz[p] = vz_in[i];
        end
      end
      yf[p] = $signed(Y_W'({yorg, 4'd0})) - Y_W'(sy[p]);
    end
  end

  // Divider operands follow the edge being set up.
  always_comb begin
    case (state)
      S_DIV0: begin
        div_req.dx = DX_W'(vx0) - DX_W'(vx2);
        div_req.dy = DX_W'(y - yv2);
      end
      S_DIV1: begin
        div_req.dx = DX_W'(vx0) - DX_W'(vx1);
        div_req.dy = DX_W'(y - yv1);
      end
      default: begin
        div_req.dx = DX_W'(vx1) - DX_W'(vx2);
        div_req.dy = DX_W'(yv1 - yv2);
      end
    endcase
    dy_zero = (div_req.dy == '0);
    div_req.start = !div_run && !dy_zero &&
                    ((state == S_DIV0) || (state == S_DIV1) || (state == S_DIV2));
  end

  always_comb begin
    edges_ok = ok1 && edge_ok(s1, x1) && ok0 && edge_ok(s0, x0);
    y_done   = y >= (half ? yv2 : yv1);
    y_off    = y >= Y_LIMIT;
    y_neg    = y < 0;
    rmw_go   = !pend_valid || out_free;
    ram_we   = (state == S_RMW) && rmw_go;
  end

  // Column span of the current scanline: from the truncated left edge while the
  // column lies below the right edge and inside the active width.
  always_comb begin
    mn = (x0 < x1) ? x0 : x1;
    mx = (x0 < x1) ? x1 : x0;
    if (mn < 0) begin
      col_start = '0;
    end else if (mn[X_W-1:16] >= 32'(SCREEN_W)) begin
      col_start = COL_W'(SCREEN_W);
    end else begin
      col_start = COL_W'(mn[X_W-1:16]);
    end
    if (mx <= 0) begin
      col_end = '0;
    end else if (mx[X_W-1:16] >= 32'(SCREEN_W)) begin
      col_end = COL_W'(SCREEN_W);
    end else begin
      col_end = COL_W'(mx[X_W-1:16]) + COL_W'(|mx[15:0]);
    end
    col_limit = (aw < COL_W'(SCREEN_W)) ? aw : COL_W'(SCREEN_W);
    for (int c = 0; c < SCREEN_W; c++) begin
      colmask_calc[c] = (COL_W'(c) >= col_start) && (COL_W'(c) < col_end) &&
                        (COL_W'(c) < col_limit);
    end
  end

  // Depth test across the whole row; a row never written since the last clear
  // reads as the clear depth.
  always_comb begin
    for (int c = 0; c < SCREEN_W; c++) begin
      cur_depth[c] = rvalid[rowaddr] ? $signed(row_rdata[c*16 +: 16]) : CLEAR_DEPTH;
      hit[c] = colmask[c] && (z >= cur_depth[c]);
      row_wdata[c*16 +: 16] = hit[c] ? z : cur_depth[c];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (prim.op == OP_DRAW)) begin
          state_next = S_DIV0;
        end
      end
      S_DIV0: begin
        if (dy_zero || div_rsp.done) begin
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        if (dy_zero || div_rsp.done) begin
          state_next = S_TEST_UP;
        end
      end
      S_TEST_UP: state_next = edges_ok ? S_WALK : S_DIV2;
      S_DIV2: begin
        if (dy_zero || div_rsp.done) begin
          state_next = S_TEST_LO;
        end
      end
      S_TEST_LO: state_next = edges_ok ? S_WALK : S_FIN;
      S_WALK: begin
        if (y_done) begin
          state_next = half ? S_FIN : S_DIV2;
        end else if (y_off) begin
          state_next = S_FIN;
        end else if (!y_neg) begin
          state_next = S_RMW;
        end
      end
      S_RMW: begin
        if (rmw_go) begin
          state_next = S_WALK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run    <= 1'b0;
      rvalid     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (div_req.start) begin
        div_run <= 1'b1;
      end else if (div_rsp.done) begin
        div_run <= 1'b0;
      end
      // A new beat enters the result register, or the waiting one leaves it.
      if ((ram_we && pend_valid) || ((state == S_FIN) && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && (prim.op == OP_CLEAR)) begin
        rvalid <= '0;
      end
      if (ram_we) begin
        rvalid[rowaddr] <= 1'b1;
        pend_valid      <= 1'b1;
      end
      if ((state == S_FIN) && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          vx0  <= sx[0];
          vx1  <= sx[1];
          vx2  <= sx[2];
          y    <= yf[0];
          yv1  <= yf[1];
          yv2  <= yf[2];
          z    <= sz[0];
          rgb  <= prim.face_rgb;
          x0   <= X_W'(sx[0]) <<< 12;
          x1   <= X_W'(sx[0]) <<< 12;
          half <= 1'b0;
        end
      end
      S_DIV0: begin
        if (dy_zero) begin
          ok0 <= 1'b0;
        end else if (div_rsp.done) begin
          ok0 <= 1'b1;
          s0  <= div_rsp.quot;
        end
      end
      S_DIV1, S_DIV2: begin
        if (dy_zero) begin
          ok1 <= 1'b0;
        end else if (div_rsp.done) begin
          ok1 <= 1'b1;
          s1  <= div_rsp.quot;
        end
      end
      S_TEST_UP: begin
        // A failed upper test restarts the short edge at the middle vertex.
        if (!edges_ok) begin
          x1 <= X_W'(vx1) <<< 12;
        end
      end
      S_TEST_LO: half <= 1'b1;
      S_WALK: begin
        if (!y_done && !y_off) begin
          if (y_neg) begin
            x0 <= x0 + X_W'(s0);
            x1 <= x1 + X_W'(s1);
            y  <= y + Y_STEP;
          end else begin
            rowaddr <= y[4 +: ROW_W];
            colmask <= colmask_calc;
          end
        end
      end
      S_RMW: begin
        if (rmw_go) begin
          if (pend_valid) begin
            out_row  <= 6'(pend_row);
            out_mask <= pend_mask;
            out_rgb  <= rgb;
            out_last <= 1'b0;
          end
          pend_row  <= rowaddr;
          pend_mask <= 64'(hit);
          x0 <= x0 + X_W'(s0);
          x1 <= x1 + X_W'(s1);
          y  <= y + Y_STEP;
        end
      end
      S_FIN: begin
        // The held row becomes the final beat; with no row, an empty final beat.
        if (out_free) begin
          out_row  <= pend_valid ? 6'(pend_row) : 6'd0;
          out_mask <= pend_valid ? pend_mask : 64'd0;
          out_rgb  <= rgb;
          out_last <= 1'b1;
        end
      end
      default: begin
        half <= half;
      end
    endcase
  end

  assign res.valid      = out_valid;
  assign res.row        = out_row;
  assign res.pixel_mask = out_mask;
  assign res.pixel_rgb  = out_rgb;
  assign res.last       = out_last;

endmodule

@@ src/fzr_checker.sv @@
`include "flat_triangle_zbuffer_raster_core_macros.svh"

module fzr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_row,
  input logic [63:0] out_mask,
  input logic        out_last,
  input logic        pready
);

  // A triangle beat occupies the core; a clear beat leaves it ready.
  `FZR_ASSERT_NEXT(a_draw_busy, in_valid && in_ready && in_op, !in_ready)
  `FZR_ASSERT_NEXT(a_clear_ready, in_valid && in_ready && !in_op, in_ready)
  `FZR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FZR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(out_row) && $stable(out_mask) && $stable(out_last))
  `FZR_ASSERT_SAME(a_pready, 1'b1, pready)

endmodule

bind flat_triangle_zbuffer_raster_core fzr_checker u_fzr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (prim.valid),
  .in_ready (prim.ready),
  .in_op    (prim.op),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .out_row  (res.row),
  .out_mask (res.pixel_mask),
  .out_last (res.last),
  .pready   (pready)
);
